/* hdl/q4_dequant_matvec_accumulator_top_macros.svh */
// Assertion macros shared by the checker.
`ifndef Q4_DEQUANT_MATVEC_ACCUMULATOR_TOP_MACROS_SVH
`define Q4_DEQUANT_MATVEC_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define Q4_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define Q4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/q4dmv_pkg.sv */
// Types, constants and floating-point helpers for the q4 dequant matvec block.
package q4dmv_pkg;

	localparam int ROWS_DEF   = 32;
	localparam int BLOCKS_DEF = 8;

	localparam logic [1:0] MODE_ACC   = 2'd0;
	localparam logic [1:0] MODE_FLUSH = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [31:0] F32_QNAN_DEF = 32'hFFC0_0000;
	localparam logic [30:0] F32_INF_MAG  = 31'h7F80_0000;
	localparam logic [31:0] F32_QUIET    = 32'h0040_0000;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_DECODE, ST_FLUSH,
		ST_SUB, ST_SUBN, ST_MUL1, ST_MUL1N, ST_MUL2, ST_MUL2N,
		ST_ADD1, ST_ADD1N, ST_ADD2, ST_ADD2N
	} state_t;

	typedef enum logic [2:0] {OP_SUB, OP_MUL1, OP_MUL2, OP_ADD1, OP_ADD2} op_t;

	typedef struct packed {
		logic sweep;
		logic take;
		logic pre_en;
		op_t  op;
		logic post_en;
		logic part_wr;
		logic sum_wr;
		logic sum_zero;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       ok;
		logic       eoc;
		logic       out_free;
		logic       sweep_last;
	} sts_t;

	// unrounded result between align/add and normalize/round
	typedef struct packed {
		logic               spec;
		logic [31:0]        sval;
		logic               sign;
		logic signed [10:0] e;
		logic [27:0]        m;
	} fpx_t;

	function automatic logic f_is_nan(input logic [31:0] x);
		return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
	endfunction

	function automatic logic [15:0] f_bf16(input logic [31:0] x);
		logic [31:0] w;
		w = x + 32'h0000_7FFF + {31'd0, x[16]};
		if (f_is_nan(x))
			return x[31:16] | 16'h0040;
		return w[31:16];
	endfunction

	function automatic logic [31:0] f_int4(input logic [3:0] q);
		logic [1:0]  k;
		logic [22:0] f;
		k = 2'd0;
		if (q[3]) k = 2'd3;
		else if (q[2]) k = 2'd2;
		else if (q[1]) k = 2'd1;
		f = 23'(q) << (5'd23 - {3'd0, k});
		if (q == 4'd0)
			return 32'd0;
		return {1'b0, 8'(8'd127 + {6'd0, k}), f};
	endfunction

	function automatic fpx_t fadd_pre(input logic [31:0] a, input logic [31:0] b);
		fpx_t        r;
		logic [31:0] x, y;
		logic [7:0]  ex, ey, d;
		logic [26:0] ax, ay, sh;
		logic [27:0] sum;
		r = '0;
		x = a;
		y = b;
		if (a[30:0] < b[30:0]) begin
			x = b;
			y = a;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		d = ex - ey;
		ax = {(x[30:23] != 8'd0), x[22:0], 3'b000};
		ay = {(y[30:23] != 8'd0), y[22:0], 3'b000};
		if (d >= 8'd27) begin
			sh = {26'd0, |ay};
		end else begin
			sh = ay >> d;
			sh[0] = sh[0] | ((sh << d) != ay);
		end
		if (x[31] == y[31])
			sum = {1'b0, ax} + {1'b0, sh};
		else
			sum = {1'b0, ax} - {1'b0, sh};
		r.sign = (sum == 28'd0) ? (x[31] & y[31]) : x[31];
		r.e = $signed({3'b000, ex});
		r.m = sum;
		if (f_is_nan(a)) begin
			r.spec = 1'b1;
			r.sval = a | F32_QUIET;
		end else if (f_is_nan(b)) begin
			r.spec = 1'b1;
			r.sval = b | F32_QUIET;
		end else if (a[30:0] == F32_INF_MAG && b[30:0] == F32_INF_MAG && a[31] != b[31]) begin
			r.spec = 1'b1;
			r.sval = F32_QNAN_DEF;
		end else if (a[30:0] == F32_INF_MAG) begin
			r.spec = 1'b1;
			r.sval = a;
		end else if (b[30:0] == F32_INF_MAG) begin
			r.spec = 1'b1;
			r.sval = b;
		end
		return r;
	endfunction

	// operands carry bf16 values: only the top 7 fraction bits are nonzero
	function automatic fpx_t fmul_pre(input logic [31:0] a, input logic [31:0] b);
		fpx_t               r;
		logic [7:0]         ea, eb, ma, mb;
		logic [15:0]        p;
		logic signed [10:0] e, sft;
		logic [27:0]        m, m2;
		logic               az, bz, ai, bi;
		r = '0;
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma = {(a[30:23] != 8'd0), a[22:16]};
		mb = {(b[30:23] != 8'd0), b[22:16]};
		p = ma * mb;
		e = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
		m = {p, 12'd0};
		sft = 11'sd1 - e;
		if (e < 11'sd1) begin
			if (sft >= 11'sd28) begin
				m = {27'd0, |m};
			end else begin
				m2 = m >> sft[4:0];
				m = m2 | {27'd0, ((m2 << sft[4:0]) != m)};
			end
			e = 11'sd1;
		end
		r.sign = a[31] ^ b[31];
		r.e = e;
		r.m = m;
		az = (a[30:0] == 31'd0);
		bz = (b[30:0] == 31'd0);
		ai = (a[30:0] == F32_INF_MAG);
		bi = (b[30:0] == F32_INF_MAG);
		if (f_is_nan(a)) begin
			r.spec = 1'b1;
			r.sval = a | F32_QUIET;
		end else if (f_is_nan(b)) begin
			r.spec = 1'b1;
			r.sval = b | F32_QUIET;
		end else if ((ai && bz) || (bi && az)) begin
			r.spec = 1'b1;
			r.sval = F32_QNAN_DEF;
		end else if (ai || bi) begin
			r.spec = 1'b1;
			r.sval = {r.sign, F32_INF_MAG};
		end else if (az || bz) begin
			r.spec = 1'b1;
			r.sval = {r.sign, 31'd0};
		end
		return r;
	endfunction

	// normalize and round to nearest even
	function automatic logic [31:0] fpost(input fpx_t x);
		logic signed [10:0] e, lim;
		logic [27:0]        m;
		logic [4:0]         lz, sh;
		logic               found, up;
		logic [24:0]        mr;
		e = x.e;
		m = x.m;
		if (m[27]) begin
			m = {1'b0, m[27:2], m[1] | m[0]};
			e = e + 11'sd1;
		end
		lz = 5'd0;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found) begin
				if (m[i]) found = 1'b1;
				else lz = lz + 5'd1;
			end
		end
		lim = e - 11'sd1;
		sh = (lim < $signed({6'd0, lz})) ? lim[4:0] : lz;
		m = m << sh;
		e = e - $signed({6'd0, sh});
		up = m[2] & (m[1] | m[0] | m[3]);
		mr = {1'b0, m[26:3]} + {24'd0, up};
		if (mr[24]) begin
			mr = {1'b0, mr[24:1]};
			e = e + 11'sd1;
		end
		if (x.spec)
			return x.sval;
		if (x.m == 28'd0)
			return {x.sign, 31'd0};
		if (e >= 11'sd255)
			return {x.sign, F32_INF_MAG};
		return {x.sign, (mr[23] ? e[7:0] : 8'h00), mr[22:0]};
	endfunction

endpackage

/* hdl/q4_dequant_matvec_accumulator_top.sv */
// Top level of the 4-bit dequantizing matvec accumulator.
//  channel | direction | handshake            | payload
//  input   | in        | in_valid / in_ready  | mode, block/row index, weight, scale, zero, act
//  result  | out       | out_valid / out_ready| out_block, out_row, out_sum
// After reset the row sums and partials are zeroed while in_ready is held low.
// Accumulate subtracts the zero, scales, multiplies by the activation and adds to the
// partial, and at end of chunk adds into the row sum (one shared align/add and one
// normalize/round unit, each step through a register); flush waits for a free result register.
// A pending result waits in the output register while the next transaction is taken.
module q4_dequant_matvec_accumulator_top #(
	parameter int ROWS   = q4dmv_pkg::ROWS_DEF,
	parameter int BLOCKS = q4dmv_pkg::BLOCKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [3:0]  block_index,
	input  logic [4:0]  row_index,
	input  logic [3:0]  weight_nibble,
	input  logic [15:0] scale_bits,
	input  logic [15:0] zero_bits,
	input  logic [15:0] activation_bits,
	input  logic        end_of_chunk,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_block,
	output logic [4:0]  out_row,
	output logic [15:0] out_sum
);
	import q4dmv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	q4dmv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	q4dmv_datapath #(.ROWS(ROWS), .BLOCKS(BLOCKS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.block_index     (block_index),
		.row_index       (row_index),
		.weight_nibble   (weight_nibble),
		.scale_bits      (scale_bits),
		.zero_bits       (zero_bits),
		.activation_bits (activation_bits),
		.end_of_chunk    (end_of_chunk),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_block       (out_block),
		.out_row         (out_row),
		.out_sum         (out_sum)
	);

endmodule

/* hdl/q4dmv_ctrl.sv */
// Sequencer for sweep, decode, flush and the accumulate arithmetic steps.
module q4dmv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  q4dmv_pkg::sts_t    sts,
	output q4dmv_pkg::cmd_t    cmd
);
	import q4dmv_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.op = OP_SUB;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				if (sts.ok) begin
					case (sts.mode)
						MODE_ACC:   state_d = ST_SUB;
						MODE_FLUSH: state_d = ST_FLUSH;
						MODE_CLEAR: begin
							cmd.sum_wr = 1'b1;
							cmd.sum_zero = 1'b1;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.sum_wr = 1'b1;
					cmd.sum_zero = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SUB: begin
				cmd.pre_en = 1'b1;
				cmd.op = OP_SUB;
				state_d = ST_SUBN;
			end
			ST_SUBN: begin
				cmd.post_en = 1'b1;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.pre_en = 1'b1;
				cmd.op = OP_MUL1;
				state_d = ST_MUL1N;
			end
			ST_MUL1N: begin
				cmd.post_en = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.pre_en = 1'b1;
				cmd.op = OP_MUL2;
				state_d = ST_MUL2N;
			end
			ST_MUL2N: begin
				cmd.post_en = 1'b1;
				state_d = ST_ADD1;
			end
			ST_ADD1: begin
				cmd.pre_en = 1'b1;
				cmd.op = OP_ADD1;
				state_d = ST_ADD1N;
			end
			ST_ADD1N: begin
				cmd.post_en = 1'b1;
				cmd.part_wr = 1'b1;
				state_d = sts.eoc ? ST_ADD2 : ST_IDLE;
			end
			ST_ADD2: begin
				cmd.pre_en = 1'b1;
				cmd.op = OP_ADD2;
				state_d = ST_ADD2N;
			end
			ST_ADD2N: begin
				cmd.sum_wr = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hdl/q4dmv_datapath.sv */
// Item registers, row memories, shared fp align and round units, result register.
module q4dmv_datapath #(
	parameter int ROWS   = q4dmv_pkg::ROWS_DEF,
	parameter int BLOCKS = q4dmv_pkg::BLOCKS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  q4dmv_pkg::cmd_t cmd,
	output q4dmv_pkg::sts_t sts,
	input  logic [1:0]      mode,
	input  logic [3:0]      block_index,
	input  logic [4:0]      row_index,
	input  logic [3:0]      weight_nibble,
	input  logic [15:0]     scale_bits,
	input  logic [15:0]     zero_bits,
	input  logic [15:0]     activation_bits,
	input  logic            end_of_chunk,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [2:0]      out_block,
	output logic [4:0]      out_row,
	output logic [15:0]     out_sum
);
	import q4dmv_pkg::*;

	localparam int SLOTS = BLOCKS * ROWS;
	localparam int SW    = $clog2(SLOTS);
	localparam int RW    = $clog2(ROWS);

	logic [31:0] sum_mem [SLOTS];
	logic [31:0] part_mem [ROWS];

	logic [1:0]    mode_q;
	logic          ok_q, eoc_q;
	logic [2:0]    blk_q;
	logic [4:0]    row_q;
	logic [SW-1:0] slot_q;
	logic [RW-1:0] prow_q;
	logic [3:0]    q_q;
	logic [15:0]   scale_q, zero_q, act_q;
	logic [SW-1:0] sweep_q;
	logic [31:0]   sum_rd_q, part_rd_q, res_q, post_out, zero_neg;
	fpx_t          pre_in, x_s1;
	logic          out_valid_q;
	logic [2:0]    out_block_q;
	logic [4:0]    out_row_q;
	logic [15:0]   out_sum_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q  <= mode;
			ok_q    <= (int'(block_index) < BLOCKS) && (int'(row_index) < ROWS);
			eoc_q   <= end_of_chunk;
			blk_q   <= block_index[2:0];
			row_q   <= row_index;
			slot_q  <= SW'(int'(block_index) * ROWS + int'(row_index));
			prow_q  <= RW'(row_index);
			q_q     <= weight_nibble;
			scale_q <= scale_bits;
			zero_q  <= zero_bits;
			act_q   <= activation_bits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sweep_q <= '0;
		else if (cmd.sweep)
			sweep_q <= sweep_q + SW'(1);
	end

	// registered reads at the held row and slot
	always_ff @(posedge clk) begin
		sum_rd_q  <= sum_mem[slot_q];
		part_rd_q <= part_mem[prow_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			sum_mem[sweep_q] <= 32'd0;
			if (int'(sweep_q) < ROWS)
				part_mem[sweep_q[RW-1:0]] <= 32'd0;
		end else begin
			if (cmd.sum_wr)
				sum_mem[slot_q] <= cmd.sum_zero ? 32'd0 : post_out;
			if (cmd.part_wr)
				part_mem[prow_q] <= eoc_q ? 32'd0 : post_out;
		end
	end

	// q - zero as q + (-zero); a NaN zero keeps its sign
	assign zero_neg = f_is_nan({zero_q, 16'd0}) ? {zero_q, 16'd0}
		: {~zero_q[15], zero_q[14:0], 16'd0};

	always_comb begin
		case (cmd.op)
			OP_SUB:  pre_in = fadd_pre(f_int4(q_q), zero_neg);
			OP_MUL1: pre_in = fmul_pre({f_bf16(res_q), 16'd0}, {scale_q, 16'd0});
			OP_MUL2: pre_in = fmul_pre({f_bf16(res_q), 16'd0}, {act_q, 16'd0});
			OP_ADD1: pre_in = fadd_pre(part_rd_q, res_q);
			OP_ADD2: pre_in = fadd_pre(sum_rd_q, res_q);
			default: pre_in = fadd_pre(part_rd_q, res_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.pre_en)
			x_s1 <= pre_in;
	end

	assign post_out = fpost(x_s1);

	always_ff @(posedge clk) begin
		if (cmd.post_en)
			res_q <= post_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_block_q <= blk_q;
			out_row_q   <= row_q;
			out_sum_q   <= f_bf16(sum_rd_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_block = out_block_q;
	assign out_row   = out_row_q;
	assign out_sum   = out_sum_q;

	assign sts.mode       = mode_q;
	assign sts.ok         = ok_q;
	assign sts.eoc        = eoc_q;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign sts.sweep_last = (sweep_q == SW'(SLOTS - 1));

endmodule

/* hdl/q4dmv_checker.sv */
// Port-level checks for the matvec accumulator, bound to the top level.
`include "q4_dequant_matvec_accumulator_top_macros.svh"

module q4dmv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_sum
);
	import q4dmv_pkg::*;

	`Q4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sum), "stalled result changed")
	`Q4_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "transaction taken while busy")
	`Q4_ASSERT_NEXT(a_no_spurious, in_valid && in_ready && mode != MODE_FLUSH, ##1 !$rose(out_valid), "result without flush")
	`Q4_ASSERT_NOW(a_idle_on_result, $rose(out_valid), in_ready, "result shown while still busy")

endmodule

bind q4_dequant_matvec_accumulator_top q4dmv_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.mode      (mode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_sum   (out_sum)
);

/* test/q4_dequant_matvec_accumulator_top_tb.sv */
// Self-checking testbench for the q4 dequant matvec accumulator top level.
module q4_dequant_matvec_accumulator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import q4dmv_pkg::*;

	localparam int NROWS     = ROWS_DEF;
	localparam int NBLOCKS   = BLOCKS_DEF;
	localparam int LIMIT     = 400000;
	localparam int PHASE_LEN = 450;

	typedef struct {
		logic [1:0]  mode;
		logic [3:0]  blk;
		logic [4:0]  row;
		logic [3:0]  q;
		logic [15:0] sc;
		logic [15:0] zr;
		logic [15:0] ac;
		logic        eoc;
	} item_t;

	typedef struct {
		logic [2:0]  blk;
		logic [4:0]  row;
		logic [15:0] sum;
	} flush_t;

	class row_sum_board;
		logic [31:0] sums[NBLOCKS*NROWS];
		logic [31:0] partial[NROWS];
		flush_t      flush_q[$];
		int          errors;

		function new();
			foreach (sums[i]) sums[i] = '0;
			foreach (partial[i]) partial[i] = '0;
			errors = 0;
		endfunction

		function bit is_nan(logic [31:0] x);
			return x[30:23] == 8'hFF && x[22:0] != 0;
		endfunction

		// value = m/8 * 2^(e-150), rounded to nearest even
		function logic [31:0] pack_round(bit s, int e, logic [63:0] m);
			logic [63:0] mr;
			bit          up;
			if (m == 0) return {s, 31'd0};
			while (m >= 64'h800_0000) begin
				m = (m >> 1) | (m & 64'd1);
				e++;
			end
			while (m < 64'h400_0000 && e > 1) begin
				m = m << 1;
				e--;
			end
			while (e < 1) begin
				m = (m >> 1) | (m & 64'd1);
				e++;
			end
			up = m[2] & (m[1] | m[0] | m[3]);
			mr = (m >> 3) + {63'd0, up};
			if (mr[24]) begin
				mr = mr >> 1;
				e++;
			end
			if (e >= 255) return {s, 8'hFF, 23'd0};
			return {s, mr[23] ? e[7:0] : 8'd0, mr[22:0]};
		endfunction

		function logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
			logic [31:0] x, y;
			int          ex, ey, d;
			logic [63:0] mx, my, sh, sum;
			if (is_nan(a)) return a | 32'h0040_0000;
			if (is_nan(b)) return b | 32'h0040_0000;
			if (a[30:0] == 31'h7F80_0000 && b[30:0] == 31'h7F80_0000 && a[31] != b[31])
				return 32'hFFC0_0000;
			if (a[30:0] == 31'h7F80_0000) return a;
			if (b[30:0] == 31'h7F80_0000) return b;
			x = a;
			y = b;
			if (a[30:0] < b[30:0]) begin
				x = b;
				y = a;
			end
			ex = (x[30:23] == 0) ? 1 : int'(x[30:23]);
			ey = (y[30:23] == 0) ? 1 : int'(y[30:23]);
			d = ex - ey;
			mx = {40'd0, x[30:23] != 0, x[22:0]} << 3;
			my = {40'd0, y[30:23] != 0, y[22:0]} << 3;
			if (d >= 40) sh = {63'd0, my != 0};
			else sh = (my >> d) | {63'd0, (my & ((64'd1 << d) - 1)) != 0};
			sum = (x[31] == y[31]) ? mx + sh : mx - sh;
			if (sum == 0) return {x[31] & y[31], 31'd0};
			return pack_round(x[31], ex, sum);
		endfunction

		function logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
			if (is_nan(a)) return a | 32'h0040_0000;
			if (is_nan(b)) return b | 32'h0040_0000;
			return f_add(a, {~b[31], b[30:0]});
		endfunction

		function logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
			bit          s, az, bz, ai, bi;
			int          ea, eb;
			logic [63:0] ma, mb;
			s = a[31] ^ b[31];
			az = a[30:0] == 0;
			bz = b[30:0] == 0;
			ai = a[30:0] == 31'h7F80_0000;
			bi = b[30:0] == 31'h7F80_0000;
			if (is_nan(a)) return a | 32'h0040_0000;
			if (is_nan(b)) return b | 32'h0040_0000;
			if ((ai && bz) || (bi && az)) return 32'hFFC0_0000;
			if (ai || bi) return {s, 8'hFF, 23'd0};
			if (az || bz) return {s, 31'd0};
			ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
			eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
			ma = {40'd0, a[30:23] != 0, a[22:0]};
			mb = {40'd0, b[30:23] != 0, b[22:0]};
			return pack_round(s, ea + eb - 150, (ma * mb) << 3);
		endfunction

		function logic [15:0] to_bf16(logic [31:0] w);
			if (is_nan(w)) return w[31:16] | 16'h0040;
			w = w + 32'h7FFF + {31'd0, w[16]};
			return w[31:16];
		endfunction

		function logic [31:0] bf16_round(logic [31:0] w);
			return {to_bf16(w), 16'h0};
		endfunction

		function void note(item_t it);
			logic [31:0] shifted, deq, prod;
			int          slot;
			flush_t      f;
			if (it.blk >= NBLOCKS) return;
			slot = it.blk * NROWS + it.row;
			case (it.mode)
				MODE_ACC: begin
					shifted = bf16_round(f_sub(pack_round(0, 150, {60'd0, it.q} << 3),
						{it.zr, 16'h0}));
					deq = bf16_round(f_mul(shifted, {it.sc, 16'h0}));
					prod = f_mul(deq, {it.ac, 16'h0});
					partial[it.row] = f_add(partial[it.row], prod);
					if (it.eoc) begin
						sums[slot] = f_add(sums[slot], partial[it.row]);
						partial[it.row] = '0;
					end
				end
				MODE_FLUSH: begin
					f.blk = it.blk[2:0];
					f.row = it.row;
					f.sum = to_bf16(sums[slot]);
					flush_q.push_back(f);
					sums[slot] = '0;
				end
				MODE_CLEAR: sums[slot] = '0;
				default: ;
			endcase
		endfunction

		function void check(flush_t got);
			flush_t want;
			if (flush_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result blk=%0d row=%0d sum=%h", got.blk, got.row,
						got.sum);
				return;
			end
			want = flush_q.pop_front();
			if (got.blk !== want.blk || got.row !== want.row || got.sum !== want.sum) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected blk=%0d row=%0d sum=%h, got blk=%0d row=%0d sum=%h",
						want.blk, want.row, want.sum, got.blk, got.row, got.sum);
			end
		endfunction

		function int pending();
			return flush_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = '0;
	logic [3:0]  block_index = '0;
	logic [4:0]  row_index = '0;
	logic [3:0]  weight_nibble = '0;
	logic [15:0] scale_bits = '0;
	logic [15:0] zero_bits = '0;
	logic [15:0] activation_bits = '0;
	logic        end_of_chunk = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  out_block;
	logic [4:0]  out_row;
	logic [15:0] out_sum;

	row_sum_board sb = new();
	int send_idle = 0;
	int recv_stall = 0;
	int cycles = 0;

	q4_dequant_matvec_accumulator_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .block_index(block_index), .row_index(row_index),
		.weight_nibble(weight_nibble), .scale_bits(scale_bits), .zero_bits(zero_bits),
		.activation_bits(activation_bits), .end_of_chunk(end_of_chunk),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_block(out_block), .out_row(out_row), .out_sum(out_sum)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("q4_dequant_matvec_accumulator_top test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		flush_t r;
		if (arst_n && out_valid && out_ready) begin
			r.blk = out_block;
			r.row = out_row;
			r.sum = out_sum;
			sb.check(r);
		end
	end

	task automatic drive(item_t it);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		mode = it.mode;
		block_index = it.blk;
		row_index = it.row;
		weight_nibble = it.q;
		scale_bits = it.sc;
		zero_bits = it.zr;
		activation_bits = it.ac;
		end_of_chunk = it.eoc;
		do @(posedge clk); while (!in_ready);
		sb.note(it);
	endtask

	task automatic send(logic [1:0] m, logic [3:0] b, logic [4:0] r, logic [3:0] q,
			logic [15:0] sc, logic [15:0] zr, logic [15:0] ac, logic e);
		item_t it;
		it = '{m, b, r, q, sc, zr, ac, e};
		drive(it);
	endtask

	function automatic logic [15:0] bf16_near(int lo, int hi, int neg_pct);
		logic [7:0] ex;
		ex = 8'($urandom_range(hi, lo));
		return {$urandom_range(99) < neg_pct, ex, 7'($urandom)};
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int    r;
		if ($urandom_range(99) < 20) begin
			it = '{2'($urandom), 4'($urandom), 5'($urandom), 4'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)};
			return it;
		end
		r = $urandom_range(99);
		it.mode = (r < 72) ? MODE_ACC : (r < 86) ? MODE_FLUSH : (r < 94) ? MODE_CLEAR : 2'd3;
		it.blk = ($urandom_range(99) < 90) ? 4'($urandom_range(NBLOCKS - 1))
			: 4'($urandom_range(15, NBLOCKS));
		it.row = ($urandom_range(99) < 70) ? 5'($urandom_range(3)) : 5'($urandom);
		it.q = 4'($urandom);
		it.sc = bf16_near(116, 126, 10);
		it.zr = ($urandom_range(1)) ? bf16_near(126, 130, 5) : 16'h4100;
		it.ac = bf16_near(118, 130, 50);
		it.eoc = ($urandom_range(99) < 25);
		return it;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extremes and special values
		send(MODE_ACC, 0, 0, 4'd15, 16'h3F80, 16'h0000, 16'h3F80, 0);
		send(MODE_ACC, 0, 0, 4'd0, 16'h3F80, 16'h4100, 16'hBF80, 1);
		send(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0);
		send(MODE_ACC, 7, 31, 4'd15, 16'h7F7F, 16'hFFFF, 16'h7F7F, 1);
		send(MODE_FLUSH, 7, 31, 0, 0, 0, 0, 0);
		send(MODE_ACC, 1, 2, 4'd3, 16'h0001, 16'h8001, 16'h0080, 1);
		send(MODE_FLUSH, 1, 2, 0, 0, 0, 0, 0);
		send(MODE_ACC, 1, 3, 4'd9, 16'h7FC1, 16'h0000, 16'h3F80, 1);
		send(MODE_FLUSH, 1, 3, 0, 0, 0, 0, 0);
		send(MODE_ACC, 2, 4, 4'd5, 16'h3F80, 16'h0000, 16'h7F80, 0);
		send(MODE_ACC, 2, 4, 4'd5, 16'h3F80, 16'h0000, 16'hFF80, 1);
		send(MODE_FLUSH, 2, 4, 0, 0, 0, 0, 0);
		send(MODE_ACC, 3, 5, 4'd8, 16'h0000, 16'h4100, 16'h7F80, 1);
		send(MODE_FLUSH, 3, 5, 0, 0, 0, 0, 0);
		send(MODE_ACC, 4, 6, 4'd12, 16'h3E00, 16'h4080, 16'h4000, 1);
		send(MODE_CLEAR, 4, 6, 0, 0, 0, 0, 0);
		send(MODE_FLUSH, 4, 6, 0, 0, 0, 0, 0);
		send(MODE_ACC, 8, 7, 4'd15, 16'h3F80, 16'h0000, 16'h3F80, 1);
		send(MODE_FLUSH, 15, 7, 0, 0, 0, 0, 0);
		send(2'd3, 0, 0, 4'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
		send(MODE_FLUSH, 0, 0, 0, 0, 0, 0, 0);

		// hold off until every flush is back
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() > 0) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 55; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 55; end
				default: begin send_idle = 14; recv_stall = 14; end
			endcase
			for (int i = 0; i < PHASE_LEN; i++) drive(rand_item());
		end
		@(negedge clk);
		in_valid = 1'b0;
		recv_stall = 0;

		while (sb.pending() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("q4_dequant_matvec_accumulator_top test passed");
		else
			$display("q4_dequant_matvec_accumulator_top test failed");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/q4dmv_pkg.sv
hdl/q4dmv_ctrl.sv
hdl/q4dmv_datapath.sv
hdl/q4_dequant_matvec_accumulator_top.sv
hdl/q4dmv_checker.sv
test/q4_dequant_matvec_accumulator_top_tb.sv
